### design/first_fit_block_placer_macros.svh
// assertion macros shared by the first-fit block placer modules
// depends on nothing; included by the controller and the datapath
`ifndef FIRST_FIT_BLOCK_PLACER_MACROS_SVH
`define FIRST_FIT_BLOCK_PLACER_MACROS_SVH

// condition holds at every clock edge out of reset
`define FFBP_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FFBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define FFBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ffbp_pkg.sv
// package for the first-fit block placer: sizes, command codes, control structs
// depends on nothing
`default_nettype none

package ffbp_pkg;

    // table geometry
    localparam int BLOCKS     = 16;
    localparam int SIZE_WIDTH = 16;
    localparam int IDX_W      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W      = $clog2(BLOCKS + 1);

    // field widths
    localparam int CMD_W  = 1;
    localparam int BIDX_W = 4;
    localparam int SVAL_W = 16;
    localparam int CFG_W  = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_PLACE = 1'b1;

    // blocks_in_use after reset
    localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RESET = 5'd16;

    typedef logic [SIZE_WIDTH-1:0] t_size;

    // controller to datapath
    typedef struct packed {
        logic start;     // capture the input beat, load writes the table
        logic step;      // move the scan to the next block
        logic out_load;  // finish the item into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_place;   // captured command places a page
        logic scan_done;  // fit found or scan ran past the blocks in use
    } t_dp_stat;

endpackage

`default_nettype wire

### design/first_fit_block_placer.sv
// First-fit block placer, top level.
// Input channel (i_in_valid / o_in_ready) carries one beat per command: a load
// writes the free size of one block, a place scans the blocks in use (at most
// 16, from block 0) and takes the page from the first block with enough room.
// Output channel (o_out_valid / i_out_ready) returns one beat per command:
// found, placed block index and the size left in that block (zeros for a load
// or for no fit).
// Sequence: a load passes through S_LOAD_DONE into the output register; a place
// scans in S_SCAN, comparing up to min(blocks_in_use, 16) blocks, and finishes
// at a fit or at the scan end; one table entry is compared per cycle.
// Flow: one command at a time, the next one is accepted in the cycle
// its predecessor's result can first be taken.
// blocks_in_use is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while idle, the block does not enforce this. Reset clears every
// block's free size to zero and sets blocks_in_use to 16. A result waits in the
// output register while the receiver stalls; the next command may be accepted
// meanwhile, but it finishes only once that result has been taken.
// depends on ffbp_pkg, ffbp_ctrl, ffbp_datapath
`default_nettype none

module first_fit_block_placer (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire [ffbp_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire [ffbp_pkg::CMD_W-1:0]   i_command,
    input  wire [ffbp_pkg::BIDX_W-1:0]  i_block_index,
    input  wire [ffbp_pkg::SVAL_W-1:0]  i_size_value,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic                        o_found,
    output logic [ffbp_pkg::BIDX_W-1:0] o_placed_block,
    output logic [ffbp_pkg::SVAL_W-1:0] o_remaining_after
);
    import ffbp_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing and handshakes
    ffbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_is_load   (i_command == CMD_LOAD),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // table, scan and output payload
    ffbp_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_command         (i_command),
        .i_block_index     (i_block_index),
        .i_size_value      (i_size_value),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .o_found           (o_found),
        .o_placed_block    (o_placed_block),
        .o_remaining_after (o_remaining_after)
    );

endmodule

`default_nettype wire

### design/ffbp_datapath.sv
// datapath of the first-fit block placer: free-size table, scan counter, output register
// depends on ffbp_pkg and first_fit_block_placer_macros.svh
`default_nettype none
`include "first_fit_block_placer_macros.svh"

module ffbp_datapath (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cfg_wr_en,
    input  wire [ffbp_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  wire [ffbp_pkg::CMD_W-1:0] i_command,
    input  wire [ffbp_pkg::BIDX_W-1:0] i_block_index,
    input  wire [ffbp_pkg::SVAL_W-1:0] i_size_value,
    input  wire ffbp_pkg::t_dp_cmd    i_cmd,
    output ffbp_pkg::t_dp_stat        o_stat,
    output logic                      o_found,
    output logic [ffbp_pkg::BIDX_W-1:0] o_placed_block,
    output logic [ffbp_pkg::SVAL_W-1:0] o_remaining_after
);
    import ffbp_pkg::*;

    t_size              r_free [BLOCKS];
    logic [CFG_W-1:0]   r_blocks_in_use;
    logic               r_is_place;
    t_size              r_page;
    logic [CNT_W-1:0]   r_scan_cnt;
    logic [CNT_W-1:0]   r_limit;
    logic               r_found;
    logic [BIDX_W-1:0]  r_placed_block;
    logic [SVAL_W-1:0]  r_remaining;

    logic [IDX_W-1:0]   scan_idx;
    logic [IDX_W-1:0]   load_idx;
    logic               load_in_range;
    logic [CNT_W-1:0]   n_limit;
    logic               scan_end;
    logic               hit;
    t_size              n_rem;
    logic               res_found;

    // scan position and entry compare
    assign scan_idx  = r_scan_cnt[IDX_W-1:0];
    assign load_idx  = IDX_W'(i_block_index);
    assign load_in_range = (32'(i_block_index) < 32'(BLOCKS));
    assign scan_end  = (r_scan_cnt >= r_limit);
    assign hit       = (r_page <= r_free[scan_idx]);
    assign n_rem     = r_free[scan_idx] - r_page;
    assign res_found = r_is_place && !scan_end && hit;

    // scan length saturates at the table depth
    assign n_limit = (32'(r_blocks_in_use) > 32'(BLOCKS)) ? CNT_W'(BLOCKS)
                                                          : CNT_W'(r_blocks_in_use);

    assign o_stat.is_place  = r_is_place;
    assign o_stat.scan_done = scan_end || hit;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= BLOCKS_IN_USE_RESET;
        end else if (i_cfg_wr_en) begin
            r_blocks_in_use <= i_cfg_wr_data;
        end
    end

    // free-size table: cleared at reset, written by a load or a placement
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BLOCKS; k++) begin
                r_free[k] <= '0;
            end
        end else if (i_cmd.start && (i_command == CMD_LOAD) && load_in_range) begin
            r_free[load_idx] <= SIZE_WIDTH'(i_size_value);
        end else if (i_cmd.out_load && res_found) begin
            r_free[scan_idx] <= n_rem;
        end
    end

    // captured command, page size, scan counter and limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_place <= 1'b0;
            r_scan_cnt <= '0;
            r_limit    <= '0;
        end else if (i_cmd.start) begin
            r_is_place <= (i_command == CMD_PLACE);
            r_scan_cnt <= '0;
            r_limit    <= n_limit;
        end else if (i_cmd.step) begin
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page <= SIZE_WIDTH'(i_size_value);
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_found        <= res_found;
            r_placed_block <= res_found ? BIDX_W'(r_scan_cnt) : '0;
            r_remaining    <= res_found ? SVAL_W'(n_rem) : '0;
        end
    end

    assign o_found           = r_found;
    assign o_placed_block    = r_placed_block;
    assign o_remaining_after = r_remaining;

    // checks
    `FFBP_ASSERT_ALWAYS(a_cnt_within_limit, i_clk, i_rst_n, r_scan_cnt <= r_limit,
        "scan counter ran past the limit")
    `FFBP_ASSERT_NEXT(a_start_clears_cnt, i_clk, i_rst_n, i_cmd.start, r_scan_cnt == '0,
        "scan counter not cleared at start")
    `FFBP_ASSERT_IMPLY(a_step_not_done, i_clk, i_rst_n, i_cmd.step,
        r_is_place && !scan_end && !hit, "scan stepped past a fit or the end")

endmodule

`default_nettype wire

### design/ffbp_ctrl.sv
// controller of the first-fit block placer: item sequencing and both handshakes
// depends on ffbp_pkg and first_fit_block_placer_macros.svh
`default_nettype none
`include "first_fit_block_placer_macros.svh"

module ffbp_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  wire                 i_is_load,
    input  wire ffbp_pkg::t_dp_stat i_stat,
    output ffbp_pkg::t_dp_cmd   o_cmd
);
    import ffbp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD_DONE,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && r_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // commands to the datapath
    always_comb begin
        o_cmd.start    = accept;
        o_cmd.step     = (r_state == S_SCAN) && !i_stat.scan_done;
        o_cmd.out_load = out_free && ((r_state == S_LOAD_DONE) ||
                                      ((r_state == S_SCAN) && i_stat.scan_done));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_is_load ? S_LOAD_DONE : S_SCAN;
                end
            end
            S_LOAD_DONE, S_SCAN: begin
                if (o_cmd.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    // checks
    `FFBP_ASSERT_ALWAYS(a_ready_in_idle, i_clk, i_rst_n, r_in_ready == (r_state == S_IDLE),
        "input ready out of step with idle state")
    `FFBP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, !r_in_ready && (r_state != S_IDLE),
        "controller still idle after an accepted beat")
    `FFBP_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && !i_out_ready,
        r_out_valid, "pending result dropped before it was taken")
    `FFBP_ASSERT_IMPLY(a_scan_is_place, i_clk, i_rst_n, r_state == S_SCAN, i_stat.is_place,
        "scan running for a load command")

endmodule

`default_nettype wire
